### rtl/cfu_pkg.sv
// cluster feature update: shared types, sizes and saturating helpers
// used by the top level and the serial divider; depends on nothing
package cfu_pkg;

   localparam int ENTRIES   = 64;
   localparam int MAX_LEN   = 64;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int ELEM_W    = $clog2(MAX_LEN);
   localparam int LEN_W     = ELEM_W + 1;
   localparam int SUM_AW    = IDX_W + ELEM_W;
   localparam int NUM_W     = 80;
   localparam int DVS_W     = 32;
   localparam int QCNT_W    = 7;

   // csr register indexes
   localparam logic [1:0] CSR_LEN  = 2'd0;
   localparam logic [1:0] CSR_MODE = 2'd1;
   localparam logic [1:0] CSR_THR  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_UFLOW = 2'd2;

   // per-entry scalar record
   typedef struct packed {
      logic [15:0] cnt;
      logic [63:0] ssq;
      logic [31:0] path;
      logic [31:0] dcnt;
   } rec_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? {32{1'b1}} : s[31:0];
   endfunction

   function automatic logic [31:0] sub_sat32(input logic [31:0] a, input logic [31:0] b);
      return (b > a) ? 32'd0 : a - b;
   endfunction

   // clamp a 34-bit signed sum to signed 32 bits
   function automatic logic [31:0] sat_s32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -34'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

endpackage

### rtl/cfu_div.sv
// cluster feature update: restoring divider, one quotient bit per cycle
// depends on cfu_pkg for widths and the request / response structs
module cfu_div
   import cfu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [NUM_W-1:0]  num_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DVS_W:0]    rem_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DVS_W:0]    trial;
   logic              fits;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff[DVS_W-1:0], num_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= QCNT_W'(NUM_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // datapath: quotient bits fill the dividend register from the bottom
   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff <= req.dividend;
         dvs_ff <= req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, dvs_ff}) : trial;
         num_ff <= {num_ff[NUM_W-2:0], fits};
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

endmodule

### rtl/clustering_feature_update_top.sv
// cluster feature update top level: sequencer, shared 32x32 multiplier,
// feature memories and result register; depends on cfu_pkg and cfu_div
//
// channel | direction | payload
// req     | in        | tdata: entry_index, element_sum, element_position, point_count,
//         |           |        sum_squares, path_count, path_dist_count, source_id,
//         |           |        force_add; tuser: operation
// rsp     | out       | tdata: accepted, radius_sq, entry_count, status
// csr     | in        | write enable, index, data (vector_length, position_mode, threshold)
//
// each element item goes through read, combine and two squares on the shared multiplier
// the last element adds the final multiplier steps and a serial divide (skipped for a zero
// count), plus a row copy when an add is taken or an untouched entry is subtracted
// synchronous reset clears the entry valid bits; no clearing pass is needed
// a result waits in the output register; a new last element stalls only if it is still held
module clustering_feature_update_top
   import cfu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index, element_sum, element_position, point_count, sum_squares,
   // path_count, path_dist_count, source_id, force_add
   input  logic [199:0] req_tdata,
   // operation
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accepted, radius_sq, entry_count, status
   output logic [87:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_wdata
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_ELEM = 5'd1;
   localparam logic [4:0] S_SQC  = 5'd2;
   localparam logic [4:0] S_SQD  = 5'd3;
   localparam logic [4:0] S_ACCD = 5'd4;
   localparam logic [4:0] S_F0   = 5'd5;
   localparam logic [4:0] S_F1   = 5'd6;
   localparam logic [4:0] S_F2   = 5'd7;
   localparam logic [4:0] S_F3   = 5'd8;
   localparam logic [4:0] S_F4   = 5'd9;
   localparam logic [4:0] S_F5   = 5'd10;
   localparam logic [4:0] S_DIV  = 5'd11;
   localparam logic [4:0] S_DEC  = 5'd12;
   localparam logic [4:0] S_CPRD = 5'd13;
   localparam logic [4:0] S_CPWR = 5'd14;
   localparam logic [4:0] S_OUT  = 5'd15;

   // input field unpacking
   logic [IDX_W-1:0]   in_idx;
   logic signed [23:0] in_sum;
   logic signed [11:0] in_pos;
   logic [15:0]        in_cnt;
   logic [39:0]        in_ssq;
   logic [31:0]        in_path;
   logic [31:0]        in_dist;
   logic               in_force;
   logic               req_acc;

   assign in_idx   = req_tdata[5:0];
   assign in_sum   = req_tdata[29:6];
   assign in_pos   = req_tdata[41:30];
   assign in_cnt   = req_tdata[57:42];
   assign in_ssq   = req_tdata[97:58];
   assign in_path  = req_tdata[129:98];
   assign in_dist  = req_tdata[161:130];
   assign in_force = req_tdata[194];

   // configuration registers
   logic [6:0]  cfg_len_ff;
   logic        cfg_mode_ff;
   logic [23:0] cfg_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff  <= 7'd64;
         cfg_mode_ff <= 1'b0;
         cfg_thr_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEN:  cfg_len_ff  <= csr_wdata[6:0];
            CSR_MODE: cfg_mode_ff <= csr_wdata[0];
            CSR_THR:  cfg_thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control and operation registers
   logic [4:0]        state_ff;
   logic [LEN_W-1:0]  elem_ff;
   logic [LEN_W-1:0]  cp_ff;
   logic              op_sub_ff;
   logic [IDX_W-1:0]  op_idx_ff;
   logic [LEN_W-1:0]  op_len_ff;
   logic              op_mode_ff;
   logic [23:0]       op_thr_ff;
   logic [15:0]       op_cnt_ff;
   logic [39:0]       op_ssq_ff;
   logic [31:0]       op_path_ff;
   logic [31:0]       op_dist_ff;
   logic              op_force_ff;
   logic signed [23:0] xs_ff;
   logic signed [11:0] xp_ff;
   logic [ENTRIES-1:0] vld_ff;
   logic              ent_vld_ff;
   rec_type           rec_rd_ff;
   logic [31:0]       sum_rd_ff;
   logic [11:0]       pos_rd_ff;
   logic [31:0]       scr_rd_ff;
   logic [31:0]       mag_c_ff;
   logic [24:0]       mag_d_ff;
   logic [63:0]       prod_ff;
   logic [63:0]       acc0_ff;
   logic [63:0]       acc1_ff;
   logic [15:0]       n_ff;
   logic [63:0]       ssq_ff;
   logic              uf_ff;
   logic [47:0]       p0_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic              radz_ff;
   logic [47:0]       tt_ff;
   logic              rsp_valid_ff;
   logic              res_ok_ff;
   logic [62:0]       res_rad_ff;
   logic [15:0]       res_cnt_ff;
   logic [1:0]        res_st_ff;

   rec_type           ent;
   logic              op_empty;
   logic [6:0]        len_clamp;
   logic              last_elem;

   // memories
   logic [31:0] sum_mem [ENTRIES*MAX_LEN];
   logic [11:0] pos_mem [ENTRIES*MAX_LEN];
   logic [31:0] scr_mem [MAX_LEN];
   rec_type     rec_mem [ENTRIES];

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign ent        = ent_vld_ff ? rec_rd_ff : '0;
   assign op_empty   = !op_sub_ff && (ent.cnt == 16'd0);
   assign last_elem  = (elem_ff + 1'b1) >= op_len_ff;

   always_comb begin
      if (cfg_len_ff == 7'd0) len_clamp = 7'd1;
      else if (cfg_len_ff > 7'(MAX_LEN)) len_clamp = 7'(MAX_LEN);
      else len_clamp = cfg_len_ff;
   end

   // memory read address: element 0 takes the index from the item itself
   logic [IDX_W-1:0]  rd_idx;
   logic [SUM_AW-1:0] rd_addr;
   assign rd_idx  = (elem_ff == '0) ? in_idx : op_idx_ff;
   assign rd_addr = {rd_idx, elem_ff[ELEM_W-1:0]};

   // element combine
   logic signed [31:0] base_sum;
   logic signed [11:0] pos_val;
   logic signed [33:0] comb_wide;
   logic [31:0]        comb_c;
   logic signed [24:0] diff_d;

   assign base_sum  = ent_vld_ff ? $signed(sum_rd_ff) : 32'sd0;
   assign pos_val   = op_empty ? xp_ff : $signed(pos_rd_ff);
   assign comb_wide = op_sub_ff ? (34'(base_sum) - 34'(xs_ff)) : (34'(base_sum) + 34'(xs_ff));
   assign comb_c    = sat_s32(comb_wide);
   assign diff_d    = 25'(pos_val) - 25'(xs_ff);

   // shared multiplier operand select
   logic [31:0] mul_a;
   logic [31:0] mul_b;

   always_comb begin
      case (state_ff)
         S_SQC: begin
            mul_a = mag_c_ff;
            mul_b = mag_c_ff;
         end
         S_SQD: begin
            mul_a = 32'(mag_d_ff);
            mul_b = 32'(mag_d_ff);
         end
         S_F1: begin
            mul_a = ssq_ff[31:0];
            mul_b = 32'(n_ff);
         end
         S_F2: begin
            mul_a = ssq_ff[63:32];
            mul_b = 32'(n_ff);
         end
         S_F3: begin
            mul_a = 32'(n_ff);
            mul_b = 32'(n_ff);
         end
         S_F4: begin
            mul_a = 32'(op_thr_ff);
            mul_b = 32'(op_thr_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // final arithmetic
   logic [16:0]      n_add;
   logic [15:0]      n_new;
   logic [63:0]      ssq_new;
   logic             uf_new;
   logic [NUM_W-1:0] num_full;
   logic [62:0]      rad;
   logic [63:0]      metric;
   logic             ok;
   logic             need_copy;
   rec_type          rec_new;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   assign n_add = {1'b0, ent.cnt} + {1'b0, op_cnt_ff};

   always_comb begin
      if (op_sub_ff) begin
         uf_new  = op_cnt_ff > ent.cnt;
         n_new   = uf_new ? 16'd0 : ent.cnt - op_cnt_ff;
         ssq_new = (64'(op_ssq_ff) > ent.ssq) ? 64'd0 : ent.ssq - 64'(op_ssq_ff);
      end else begin
         uf_new  = 1'b0;
         n_new   = n_add[16] ? 16'hFFFF : n_add[15:0];
         ssq_new = add_sat64(ent.ssq, 64'(op_ssq_ff));
      end
   end

   // radius is zero for an empty count or a negative numerator
   assign num_full = NUM_W'(p0_ff) + {prod_ff[47:0], 32'd0};
   assign rad      = (radz_ff || n_ff == 16'd0) ? 63'd0 :
                     ((div_rsp.quotient[NUM_W-1:63] != '0) ? {63{1'b1}}
                                                          : div_rsp.quotient[62:0]);
   assign metric   = op_mode_ff ? acc1_ff : {1'b0, rad};
   assign ok       = op_sub_ff || op_force_ff || (metric < 64'(tt_ff));
   assign need_copy = (!op_sub_ff && ok) || (op_sub_ff && !ent_vld_ff);

   always_comb begin
      rec_new.cnt = n_ff;
      rec_new.ssq = ssq_ff;
      if (op_sub_ff) begin
         rec_new.path = sub_sat32(ent.path, op_path_ff);
         rec_new.dcnt = sub_sat32(ent.dcnt, op_dist_ff);
      end else begin
         rec_new.path = add_sat32(ent.path, op_path_ff);
         rec_new.dcnt = add_sat32(ent.dcnt, op_dist_ff);
      end
   end

   assign div_req.start    = (state_ff == S_F5) && (n_ff != 16'd0) && !radz_ff;
   assign div_req.dividend = num_ff;
   assign div_req.divisor  = dvs_ff;

   cfu_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // copy loop write control
   logic cp_in_len;
   logic cp_wr;
   assign cp_in_len = cp_ff < op_len_ff;
   assign cp_wr     = cp_in_len ? !op_sub_ff : !ent_vld_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         elem_ff      <= '0;
         cp_ff        <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_acc) state_ff <= S_ELEM;
            end
            S_ELEM: state_ff <= S_SQC;
            S_SQC:  state_ff <= S_SQD;
            S_SQD:  state_ff <= S_ACCD;
            S_ACCD: begin
               if (last_elem) begin
                  elem_ff  <= '0;
                  state_ff <= S_F0;
               end else begin
                  elem_ff  <= elem_ff + 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_F0: state_ff <= S_F1;
            S_F1: state_ff <= S_F2;
            S_F2: state_ff <= S_F3;
            S_F3: state_ff <= S_F4;
            S_F4: state_ff <= S_F5;
            S_F5: state_ff <= radz_ff || (n_ff == 16'd0) ? S_DEC : S_DIV;
            S_DIV: begin
               if (div_rsp.done) state_ff <= S_DEC;
            end
            S_DEC: begin
               cp_ff    <= '0;
               state_ff <= need_copy ? S_CPRD : S_OUT;
            end
            S_CPRD: state_ff <= S_CPWR;
            S_CPWR: begin
               if (cp_ff == LEN_W'(MAX_LEN - 1)) begin
                  if (ok) vld_ff[op_idx_ff] <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  cp_ff    <= cp_ff + 1'b1;
                  state_ff <= S_CPRD;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         xs_ff <= in_sum;
         xp_ff <= in_pos;
         if (elem_ff == '0) begin
            op_sub_ff   <= req_tuser[0];
            op_idx_ff   <= in_idx;
            op_len_ff   <= len_clamp;
            op_mode_ff  <= cfg_mode_ff;
            op_thr_ff   <= cfg_thr_ff;
            op_cnt_ff   <= in_cnt;
            op_ssq_ff   <= in_ssq;
            op_path_ff  <= in_path;
            op_dist_ff  <= in_dist;
            op_force_ff <= in_force;
            ent_vld_ff  <= vld_ff[in_idx];
            acc0_ff     <= '0;
            acc1_ff     <= '0;
         end
      end
      case (state_ff)
         S_ELEM: begin
            mag_c_ff <= comb_c[31] ? (32'd0 - comb_c) : comb_c;
            mag_d_ff <= diff_d[24] ? (25'd0 - diff_d) : diff_d;
         end
         S_SQC: prod_ff <= mul_a * mul_b;
         S_SQD: begin
            acc0_ff <= add_sat64(acc0_ff, prod_ff);
            prod_ff <= mul_a * mul_b;
         end
         S_ACCD: begin
            if (!op_sub_ff) acc1_ff <= add_sat64(acc1_ff, prod_ff);
         end
         S_F0: begin
            n_ff   <= n_new;
            ssq_ff <= ssq_new;
            uf_ff  <= uf_new;
         end
         S_F1: prod_ff <= mul_a * mul_b;
         S_F2: begin
            p0_ff   <= prod_ff[47:0];
            prod_ff <= mul_a * mul_b;
         end
         S_F3: begin
            num_ff  <= num_full;
            prod_ff <= mul_a * mul_b;
         end
         S_F4: begin
            dvs_ff  <= prod_ff[31:0];
            radz_ff <= num_ff < NUM_W'(acc0_ff);
            num_ff  <= num_ff - NUM_W'(acc0_ff);
            prod_ff <= mul_a * mul_b;
         end
         S_F5: tt_ff <= prod_ff[47:0];
         // result fields load only when the output register is free or its result is being taken
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               res_ok_ff  <= ok;
               res_rad_ff <= (n_ff == 16'd0) ? 63'd0 : rad;
               res_cnt_ff <= ok ? n_ff : ent.cnt;
               if (uf_ff) res_st_ff <= ST_UFLOW;
               else if ((ok ? n_ff : ent.cnt) == 16'd0) res_st_ff <= ST_ZERO;
               else res_st_ff <= ST_OK;
            end
         end
         default: ;
      endcase
   end

   // sum and position memories
   always_ff @(posedge clock) begin
      if (req_acc) sum_rd_ff <= sum_mem[rd_addr];
      if (state_ff == S_ELEM && op_sub_ff)
         sum_mem[{op_idx_ff, elem_ff[ELEM_W-1:0]}] <= comb_c;
      else if (state_ff == S_CPWR && cp_wr)
         sum_mem[{op_idx_ff, cp_ff[ELEM_W-1:0]}] <= cp_in_len ? scr_rd_ff : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (req_acc) pos_rd_ff <= pos_mem[rd_addr];
      if (state_ff == S_ELEM && op_empty)
         pos_mem[{op_idx_ff, elem_ff[ELEM_W-1:0]}] <= xp_ff;
   end

   // combined row scratch
   always_ff @(posedge clock) begin
      if (state_ff == S_ELEM && !op_sub_ff) scr_mem[elem_ff[ELEM_W-1:0]] <= comb_c;
      if (state_ff == S_CPRD) scr_rd_ff <= scr_mem[cp_ff[ELEM_W-1:0]];
   end

   // per-entry scalar records
   always_ff @(posedge clock) begin
      if (req_acc && elem_ff == '0) rec_rd_ff <= rec_mem[in_idx];
      if (state_ff == S_DEC && ok) rec_mem[op_idx_ff] <= rec_new;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, res_st_ff, res_cnt_ff, res_rad_ff, res_ok_ff};

endmodule

### rtl/cfu_checker.sv
// cluster feature update: port-level checks bound to the top level
// depends on the top level's ports and the status codes in cfu_pkg
module cfu_checker
   import cfu_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [87:0]  rsp_tdata
);

   // a held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before taken");

   // status never takes the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[81:80] <= ST_UFLOW)
      else $error("bad status code");

   // a rejected add never reports underflow
   a_reject_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[81:80] != ST_UFLOW)
      else $error("rejected add with underflow");

   // zero status goes with a zero count
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[81:80] == ST_ZERO |-> rsp_tdata[79:64] == 16'd0)
      else $error("zero status with nonzero count");

   // the block is not ready right after it takes an item
   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after item");

endmodule

bind clustering_feature_update_top cfu_checker u_cfu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/tb.sv
// testbench for clustering_feature_update_top: streams add and subtract features
// into the entry table and checks every result against a predictor of its own
// depends on cfu_pkg and the rtl top level
`timescale 1ns / 100ps

module tb;
   import cfu_pkg::*;

   localparam bit OP_ADD = 1'b0;
   localparam bit OP_SUB = 1'b1;
   localparam int LIMIT_CYCLES = 900000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      bit        operation;
      bit [5:0]  entry_index;
      bit [23:0] element_sum;
      bit [11:0] element_position;
      bit [15:0] point_count;
      bit [39:0] sum_squares;
      bit [31:0] path_count;
      bit [31:0] path_dist_count;
      bit [31:0] source_id;
      bit        force_add;
   } feat_item_type;

   typedef struct {
      bit        accepted;
      bit [62:0] radius_sq;
      bit [15:0] entry_count;
      bit [1:0]  status;
   } update_rsp_type;

   // table predictor and store of pending results
   class cf_scoreboard;
      int             sum_mem[ENTRIES*MAX_LEN];
      int             pos_mem[ENTRIES*MAX_LEN];
      int             pos_len[ENTRIES];
      bit [15:0]      cnt[ENTRIES];
      bit [63:0]      ssq[ENTRIES];
      int             scratch[MAX_LEN];
      bit [63:0]      acc_sum2, acc_dist;
      int             elem;
      int             cfg_len, cfg_mode, cfg_thr;
      bit             op_sub, op_force, op_empty;
      int             op_idx, op_len, op_mode, op_thr, op_cnt;
      bit [63:0]      op_ssq;
      update_rsp_type pending[$];
      int             errors, results, adds_taken, adds_refused;

      function new();
         cfg_len = 64;
         foreach (sum_mem[i]) sum_mem[i] = 0;
         foreach (pos_len[i]) pos_len[i] = 0;
         foreach (cnt[i]) begin
            cnt[i] = 0;
            ssq[i] = 0;
         end
      endfunction

      function int eff_len(int len);
         if (len == 0) return 1;
         if (len > MAX_LEN) return MAX_LEN;
         return len;
      endfunction

      function int clamp_s32(longint v);
         if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'h8000_0000;
         return int'(v);
      endfunction

      function bit [63:0] add_u64(bit [63:0] a, bit [63:0] b);
         bit [64:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[64] ? '1 : s[63:0];
      endfunction

      function bit [63:0] sq(longint v);
         bit [63:0] m;
         m = (v < 0) ? -v : v;
         return m * m;
      endfunction

      // floor((ssq*n - sum2)/n^2), clamped at zero and at 2^63-1
      function bit [62:0] radius(bit [63:0] s, bit [63:0] s2, int n);
         bit [127:0] num, q;
         if (n == 0) return 0;
         num = 128'(s) * 128'(n);
         if (num < 128'(s2)) return 0;
         q = (num - 128'(s2)) / (128'(n) * 128'(n));
         if (q > 128'h7FFF_FFFF_FFFF_FFFF) return '1;
         return q[62:0];
      endfunction

      // one accepted element item
      function void note(feat_item_type it);
         int             base, c, n;
         longint         xs;
         bit [63:0]      s, tt, metric;
         bit [62:0]      rad;
         update_rsp_type r;
         if (elem == 0) begin
            op_sub   = it.operation;
            op_idx   = it.entry_index;
            op_len   = eff_len(cfg_len);
            op_mode  = cfg_mode;
            op_thr   = cfg_thr;
            op_cnt   = it.point_count;
            op_ssq   = 64'(it.sum_squares);
            op_force = it.force_add;
            op_empty = (op_sub == OP_ADD) && (cnt[op_idx] == 0);
            if (op_empty) pos_len[op_idx] = op_len;
            acc_sum2 = 0;
            acc_dist = 0;
         end
         base = op_idx * MAX_LEN + elem;
         xs = longint'($signed(it.element_sum));
         if (op_sub == OP_ADD) begin
            if (op_empty) pos_mem[base] = int'($signed(it.element_position));
            c = clamp_s32(longint'(sum_mem[base]) + xs);
            scratch[elem] = c;
            acc_sum2 = add_u64(acc_sum2, sq(c));
            acc_dist = add_u64(acc_dist, sq(longint'(pos_mem[base]) - xs));
         end else begin
            c = clamp_s32(longint'(sum_mem[base]) - xs);
            sum_mem[base] = c;
            acc_sum2 = add_u64(acc_sum2, sq(c));
         end
         if (elem + 1 < op_len) begin
            elem++;
            return;
         end
         elem = 0;
         r.status = ST_OK;
         r.accepted = 1'b1;
         if (op_sub == OP_ADD) begin
            n = int'(cnt[op_idx]) + op_cnt;
            if (n > 65535) n = 65535;
            s = add_u64(ssq[op_idx], op_ssq);
            rad = radius(s, acc_sum2, n);
            tt = 64'(op_thr) * 64'(op_thr);
            metric = op_mode ? acc_dist : 64'(rad);
            r.accepted = (metric < tt) || op_force;
            if (r.accepted) begin
               for (int i = 0; i < op_len; i++) sum_mem[op_idx*MAX_LEN + i] = scratch[i];
               cnt[op_idx] = 16'(n);
               ssq[op_idx] = s;
               adds_taken++;
            end else begin
               adds_refused++;
            end
         end else begin
            if (op_cnt > cnt[op_idx]) begin
               n = 0;
               r.status = ST_UFLOW;
            end else begin
               n = cnt[op_idx] - op_cnt;
            end
            s = (op_ssq > ssq[op_idx]) ? 64'd0 : ssq[op_idx] - op_ssq;
            rad = radius(s, acc_sum2, n);
            cnt[op_idx] = 16'(n);
            ssq[op_idx] = s;
         end
         if (r.status == ST_OK && cnt[op_idx] == 0) r.status = ST_ZERO;
         r.radius_sq = rad;
         r.entry_count = cnt[op_idx];
         pending.push_back(r);
      endfunction

      // one accepted result item
      function void check(logic [87:0] d);
         update_rsp_type e;
         results++;
         if (pending.size() == 0) begin
            $error("result with no expectation: %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[0] !== e.accepted) begin
            $error("accepted: expected %0d actual %0d", e.accepted, d[0]);
            errors++;
         end
         if (d[63:1] !== e.radius_sq) begin
            $error("radius_sq: expected %0d actual %0d", e.radius_sq, d[63:1]);
            errors++;
         end
         if (d[79:64] !== e.entry_count) begin
            $error("entry_count: expected %0d actual %0d", e.entry_count, d[79:64]);
            errors++;
         end
         if (d[81:80] !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, d[81:80]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [23:0]  csr_wdata = '0;

   cf_scoreboard sb = new();
   bit           quiet = 1'b0;
   int           rsp_hold = 0;
   int           cycles = 0;
   int           items_sent = 0;

   clustering_feature_update_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // result side: random stall bursts
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
      end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = $urandom_range(1, 17) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   // drop the input and wait for the table to finish all pending work
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, only with nothing in flight
   task automatic csr_write(logic [1:0] idx, int data);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[23:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LEN) sb.cfg_len = data & 32'h7F;
      else if (idx == CSR_MODE) sb.cfg_mode = data & 1;
      else sb.cfg_thr = data & 32'hFF_FFFF;
      @(posedge clock);
   endtask

   task automatic set_config(int len, int mode, int thr);
      wait_idle();
      csr_write(CSR_LEN, len);
      csr_write(CSR_MODE, mode);
      csr_write(CSR_THR, thr);
   endtask

   // one item, with an optional gap ahead of it
   task automatic send_item(feat_item_type it);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tdata <= {5'b0, it.force_add, it.source_id, it.path_dist_count, it.path_count,
                    it.sum_squares, it.point_count, it.element_position, it.element_sum,
                    it.entry_index};
      req_tuser <= it.operation;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(it);
      items_sent++;
   endtask

   function automatic feat_item_type random_item();
      feat_item_type it;
      it.operation        = $urandom_range(0, 1);
      it.entry_index      = $urandom;
      it.element_sum      = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 600) - 300;
      it.element_position = $urandom;
      it.point_count      = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 20);
      it.sum_squares      = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                                                       : $urandom_range(0, 100000);
      it.path_count       = $urandom;
      it.path_dist_count  = $urandom;
      it.source_id        = $urandom;
      it.force_add        = $urandom_range(0, 1);
      return it;
   endfunction

   // stream a whole feature; later elements carry random fields, of which the block uses only sum and position
   task automatic send_feature(feat_item_type head);
      feat_item_type it;
      int            len;
      len = sb.eff_len(sb.cfg_len);
      send_item(head);
      for (int i = 1; i < len; i++) begin
         it = random_item();
         send_item(it);
      end
   endtask

   // random feature; an add goes only to an entry whose stored positions cover the current length
   task automatic random_feature(int fixed_idx);
      feat_item_type head;
      int            len;
      bit            safe;
      len = sb.eff_len(sb.cfg_len);
      head = random_item();
      head.operation = ($urandom_range(0, 2) == 0) ? OP_SUB : OP_ADD;
      if (fixed_idx >= 0) head.entry_index = fixed_idx;
      if (head.operation == OP_ADD) begin
         safe = 1'b0;
         for (int t = 0; t < 8 && !safe; t++) begin
            if (t > 0 && fixed_idx < 0) head.entry_index = $urandom;
            safe = sb.cnt[head.entry_index] == 0 || sb.pos_len[head.entry_index] >= len;
         end
         if (!safe) head.operation = OP_SUB;
      end
      send_feature(head);
   endtask

   task automatic directed_feature(bit op, int idx, int es, int ep, int pc, bit [39:0] ssq,
                                   bit frc);
      feat_item_type it;
      it = random_item();
      it.operation = op;
      it.entry_index = idx;
      it.element_sum = es;
      it.element_position = ep;
      it.point_count = pc;
      it.sum_squares = ssq;
      it.force_add = frc;
      send_feature(it);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-element features, first at threshold zero, then in position mode and at the top threshold
      set_config(1, 0, 0);
      directed_feature(OP_ADD, 0, 0, 0, 3, 40'd10, 1'b0);
      directed_feature(OP_ADD, 0, 24'h7FFFFF, 12'h7FF, 65535, '1, 1'b1);
      directed_feature(OP_ADD, 0, 24'h7FFFFF, 12'h7FF, 65535, '1, 1'b1);
      directed_feature(OP_ADD, 63, 24'h800000, 12'h800, 1, 40'd0, 1'b1);
      directed_feature(OP_SUB, 63, 24'h800000, 0, 1, 40'd5, 1'b0);
      directed_feature(OP_SUB, 63, 1, 0, 5, 40'd0, 1'b0);
      directed_feature(OP_SUB, 62, 7, 0, 0, '1, 1'b0);
      directed_feature(OP_ADD, 1, 24'h000100, 12'h100, 2, 40'd1000, 1'b1);
      directed_feature(OP_SUB, 1, 24'h000080, 0, 1, '1, 1'b0);
      directed_feature(OP_SUB, 0, 24'h7FFFFF, 0, 1000, 40'd1, 1'b0);
      csr_write(CSR_MODE, 1);
      directed_feature(OP_ADD, 2, 24'h000005, 12'h005, 1, 40'd25, 1'b0);
      csr_write(CSR_THR, 24'hFFFFFF);
      directed_feature(OP_ADD, 2, 24'h000006, 12'h000, 1, 40'd36, 1'b0);
      directed_feature(OP_ADD, 2, 24'h7FFFFF, 12'h000, 1, 40'd36, 1'b0);

      // random phases over lengths, modes and thresholds
      set_config(1, 0, $urandom_range(1000, 16777215));
      repeat (130) random_feature(-1);
      set_config(2, 1, $urandom_range(0, 16777215));
      repeat (30) random_feature(-1);
      quiet = 1'b1;
      set_config(0, 0, 24'hFFFFFF);
      repeat (40) random_feature(-1);
      quiet = 1'b0;
      set_config(3, 1, $urandom_range(0, 5000));
      repeat (25) random_feature(-1);
      set_config(127, 0, 5000);
      random_feature(-1);

      // last part: hammer one entry with large sums, no idling
      quiet = 1'b1;
      set_config(1, 0, 0);
      for (int k = 0; k < 270; k++) begin
         if (k % 9 == 8) random_feature(9);
         else directed_feature(OP_ADD, 9, (k < 200) ? 24'h7FFFFF : 24'h800000,
                               $urandom, $urandom_range(0, 300), {$urandom, $urandom}, 1'b1);
      end

      wait_idle();
      $display("%0d items sent, %0d results checked (%0d adds taken, %0d refused)",
               items_sent, sb.results, sb.adds_taken, sb.adds_refused);
      $display("covered lengths 0..127, both modes, threshold extremes and saturation");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/cfu_pkg.sv
rtl/cfu_div.sv
rtl/clustering_feature_update_top.sv
rtl/cfu_checker.sv
test/tb.sv
